@@ hdl/one_shot_periodic_timer_table_unit_macros.svh @@
// Assertion helpers used by the timer table top module.
// Both expect signals named clk and rst_n in the enclosing scope.
`ifndef ONE_SHOT_PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH
`define ONE_SHOT_PERIODIC_TIMER_TABLE_UNIT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define OSPT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define OSPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ostpt_pkg.sv @@
`timescale 1ns / 1ps
package ostpt_pkg;

  localparam int NUM_SLOTS = 8;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int TIME_W    = 31;
  localparam int TAG_W     = 16;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 3;
  localparam int FCNT_W    = 8;
  localparam int KIND_W    = 2;
  localparam int Q_DEPTH   = 2;
  localparam int QPTR_W    = $clog2(Q_DEPTH);
  localparam int QCNT_W    = $clog2(Q_DEPTH + 1);

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ONCE     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PERIODIC = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEFERRED = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL   = 3'd4;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_SCHEDULED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_ZERO_IV   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FIRED     = 3'd3;
  localparam logic [STAT_W-1:0] ST_CANCELLED = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd5;
  localparam logic [STAT_W-1:0] ST_TICK_DONE = 3'd6;

  // Timer kinds
  localparam logic [KIND_W-1:0] KIND_ONCE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PERIODIC = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEFERRED = 2'd2;

  localparam logic [FCNT_W-1:0] FCNT_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SCHED,
    OP_CANCEL
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] tv;
    logic [TAG_W-1:0]  tag;
    logic [SLOT_W-1:0] si;
  } work_t;

  typedef struct packed {
    logic [CNT_W-1:0] used_cnt;
  } back_status_t;

endpackage

@@ hdl/ostpt_in_if.sv @@
`timescale 1ns / 1ps
interface ostpt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [30:0] time_value;
  logic [15:0] tag;
  logic [2:0]  slot_index;

  modport source (output valid, command, time_value, tag, slot_index, input ready);
  modport sink (input valid, command, time_value, tag, slot_index, output ready);
endinterface

@@ hdl/ostpt_out_if.sv @@
`timescale 1ns / 1ps
interface ostpt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  slot;
  logic [15:0] fire_tag;
  logic [7:0]  fire_count;
  logic [1:0]  timer_kind;
  logic        last;

  modport source (output valid, status, slot, fire_tag, fire_count, timer_kind, last,
                  input ready);
  modport sink (input valid, status, slot, fire_tag, fire_count, timer_kind, last,
                output ready);
endinterface

@@ hdl/ostpt_front.sv @@
`timescale 1ns / 1ps
module ostpt_front (
  input  logic              clk,
  input  logic              rst_n,
  ostpt_in_if.sink          in_chan,
  output logic              q_valid,
  output ostpt_pkg::work_t  q_data,
  input  logic              q_pop
);
  import ostpt_pkg::*;

  work_t             q_mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] qcnt_r;
  work_t             cls;
  logic              cls_ok;
  logic              push;

  // Classify the incoming command, drop unused codes
  always_comb begin
    cls.op   = OP_TICK;
    cls.kind = KIND_ONCE;
    cls.tv   = in_chan.time_value;
    cls.tag  = in_chan.tag;
    cls.si   = in_chan.slot_index;
    cls_ok   = 1'b1;
    unique case (in_chan.command)
      CMD_TICK:     cls.op = OP_TICK;
      CMD_ONCE:     cls.op = OP_SCHED;
      CMD_PERIODIC: begin
        cls.op   = OP_SCHED;
        cls.kind = KIND_PERIODIC;
      end
      CMD_DEFERRED: begin
        cls.op   = OP_SCHED;
        cls.kind = KIND_DEFERRED;
      end
      CMD_CANCEL:   cls.op = OP_CANCEL;
      default:      cls_ok = 1'b0;
    endcase
  end

  assign in_chan.ready = (qcnt_r != QCNT_W'(Q_DEPTH));
  assign push          = in_chan.valid && in_chan.ready && cls_ok;
  assign q_valid       = (qcnt_r != '0);
  assign q_data        = q_mem_r[rptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= cls;
    end
  end

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      qcnt_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + 1'b1;
      end
      if (q_pop) begin
        rptr_r <= rptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        qcnt_r <= qcnt_r + 1'b1;
      end else if (!push && q_pop) begin
        qcnt_r <= qcnt_r - 1'b1;
      end
    end
  end

endmodule

@@ hdl/ostpt_div.sv @@
`timescale 1ns / 1ps
module ostpt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ostpt_pkg::TIME_W-1:0]  dividend,
  input  logic [ostpt_pkg::TIME_W-1:0]  divisor,
  output logic                          done,
  output logic [ostpt_pkg::TIME_W-1:0]  quot,
  output logic [ostpt_pkg::TIME_W-1:0]  rem
);
  import ostpt_pkg::*;

  localparam int STEP_W = $clog2(TIME_W);

  logic [TIME_W-1:0] quot_r;
  logic [TIME_W-1:0] rem_r;
  logic [TIME_W-1:0] dvs_r;
  logic [STEP_W-1:0] step_r;
  logic              run_r;
  logic              done_r;
  logic [TIME_W:0]   shifted;
  logic [TIME_W:0]   trial;
  logic              fits;

  // One restoring step per cycle
  always_comb begin
    shifted = {rem_r, quot_r[TIME_W-1]};
    trial   = shifted - {1'b0, dvs_r};
    fits    = (shifted >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        quot_r <= dividend;
        dvs_r  <= divisor;
        step_r <= STEP_W'(TIME_W - 1);
        run_r  <= 1'b1;
      end else if (run_r) begin
        rem_r  <= fits ? trial[TIME_W-1:0] : shifted[TIME_W-1:0];
        quot_r <= {quot_r[TIME_W-2:0], fits};
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

@@ hdl/ostpt_back.sv @@
`timescale 1ns / 1ps
module ostpt_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_valid,
  input  ostpt_pkg::work_t          q_data,
  output logic                      q_pop,
  ostpt_out_if.source               out_chan,
  output ostpt_pkg::back_status_t   sts
);
  import ostpt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DIVW,
    S_PEMIT,
    S_DEFER,
    S_COMPACT,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [NUM_SLOTS-1:0] valid_r;
  logic [KIND_W-1:0] kind_r  [NUM_SLOTS];
  logic [TIME_W-1:0] tl_r    [NUM_SLOTS];
  logic [TIME_W-1:0] iv_r    [NUM_SLOTS];
  logic [TAG_W-1:0]  tag_r   [NUM_SLOTS];
  logic [SLOT_W-1:0] order_r [NUM_SLOTS];
  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  idx_r;
  logic [CNT_W-1:0]  wr_r;
  logic              tick_r;
  logic [TIME_W-1:0] delta_r;
  logic [SLOT_W-1:0] cur_slot_r;

  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [TAG_W-1:0]  out_tag_r;
  logic [FCNT_W-1:0] out_cnt_r;
  logic [KIND_W-1:0] out_kind_r;
  logic              out_last_r;

  logic              emit_ok;
  logic [SLOT_W-1:0] cur;
  logic [SLOT_W-1:0] rd_slot;
  logic              rd_valid;
  logic [KIND_W-1:0] rd_kind;
  logic [TIME_W-1:0] rd_tl;
  logic [TIME_W-1:0] rd_iv;
  logic [TAG_W-1:0]  rd_tag;
  logic [TIME_W:0]   diff;
  logic              still_pos;
  logic [TIME_W-1:0] over;
  logic              scan_end;
  logic              has_free;
  logic [SLOT_W-1:0] free_slot;
  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] div_quot;
  logic [TIME_W-1:0] div_rem;
  logic [FCNT_W-1:0] per_cnt;
  logic              si_bad;

  assign emit_ok = !out_valid_r || out_chan.ready;

  // Slot read port: address follows the current step
  always_comb begin
    cur      = order_r[idx_r[SLOT_W-1:0]];
    unique case (state_r)
      S_IDLE:  rd_slot = q_data.si;
      S_PEMIT: rd_slot = cur_slot_r;
      default: rd_slot = cur;
    endcase
    rd_valid = valid_r[rd_slot];
    rd_kind  = kind_r[rd_slot];
    rd_tl    = tl_r[rd_slot];
    rd_iv    = iv_r[rd_slot];
    rd_tag   = tag_r[rd_slot];
    scan_end = (idx_r == used_r);
  end

  // Count down and overrun amount
  always_comb begin
    diff      = {1'b0, rd_tl} - {1'b0, delta_r};
    still_pos = !diff[TIME_W] && (diff[TIME_W-1:0] != '0);
    over      = TIME_W'(-diff);
  end

  // Lowest free slot
  always_comb begin
    has_free  = 1'b0;
    free_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        has_free  = 1'b1;
        free_slot = SLOT_W'(i);
      end
    end
  end

  assign si_bad    = ({1'b0, q_data.si} >= (SLOT_W + 1)'(NUM_SLOTS)) || !rd_valid;
  assign div_start = (state_r == S_SCAN) && !scan_end && rd_valid &&
                     (rd_kind == KIND_PERIODIC) && !still_pos;
  assign per_cnt   = (div_quot >= TIME_W'(FCNT_MAX)) ? FCNT_MAX
                                                    : div_quot[FCNT_W-1:0] + 1'b1;

  // Pop queue head once its immediate result can be registered
  always_comb begin
    q_pop = 1'b0;
    if (state_r == S_IDLE && q_valid) begin
      q_pop = (q_data.op == OP_TICK) ? 1'b1 : emit_ok;
    end
  end

  ostpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (over),
    .divisor  (rd_iv),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Sequencer, slot table and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            unique case (q_data.op)
              OP_TICK: begin
                delta_r <= q_data.tv;
                idx_r   <= '0;
                tick_r  <= 1'b1;
                state_r <= S_SCAN;
              end
              OP_SCHED: begin
                out_valid_r <= 1'b1;
                out_tag_r   <= q_data.tag;
                out_cnt_r   <= '0;
                out_kind_r  <= q_data.kind;
                out_last_r  <= 1'b1;
                out_slot_r  <= '0;
                if (q_data.kind == KIND_PERIODIC && q_data.tv == '0) begin
                  out_status_r <= ST_ZERO_IV;
                end else if (used_r >= CNT_W'(NUM_SLOTS) || !has_free) begin
                  out_status_r <= ST_FULL;
                end else begin
                  out_status_r            <= ST_SCHEDULED;
                  out_slot_r              <= free_slot;
                  valid_r[free_slot]      <= 1'b1;
                  kind_r[free_slot]       <= q_data.kind;
                  tl_r[free_slot]         <= (q_data.kind == KIND_DEFERRED) ? '0 : q_data.tv;
                  iv_r[free_slot]         <= q_data.tv;
                  tag_r[free_slot]        <= q_data.tag;
                  order_r[used_r[SLOT_W-1:0]] <= free_slot;
                  used_r                  <= used_r + 1'b1;
                end
              end
              OP_CANCEL: begin
                out_valid_r <= 1'b1;
                out_slot_r  <= q_data.si;
                out_cnt_r   <= '0;
                out_last_r  <= 1'b1;
                if (si_bad) begin
                  out_status_r <= ST_EMPTY;
                  out_tag_r    <= '0;
                  out_kind_r   <= KIND_ONCE;
                end else begin
                  out_status_r      <= ST_CANCELLED;
                  out_tag_r         <= rd_tag;
                  out_kind_r        <= rd_kind;
                  valid_r[rd_slot]  <= 1'b0;
                  idx_r             <= '0;
                  wr_r              <= '0;
                  tick_r            <= 1'b0;
                  state_r           <= S_COMPACT;
                end
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            idx_r   <= '0;
            state_r <= S_DEFER;
          end else if (!rd_valid || rd_kind == KIND_DEFERRED) begin
            idx_r <= idx_r + 1'b1;
          end else if (still_pos) begin
            tl_r[cur] <= diff[TIME_W-1:0];
            idx_r     <= idx_r + 1'b1;
          end else if (rd_kind == KIND_ONCE) begin
            if (emit_ok) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_FIRED;
              out_slot_r   <= cur;
              out_tag_r    <= rd_tag;
              out_cnt_r    <= FCNT_W'(1);
              out_kind_r   <= KIND_ONCE;
              out_last_r   <= 1'b0;
              valid_r[cur] <= 1'b0;
              idx_r        <= idx_r + 1'b1;
            end
          end else begin
            cur_slot_r <= cur;
            state_r    <= S_DIVW;
          end
        end
        S_DIVW: begin
          if (div_done) begin
            state_r <= S_PEMIT;
          end
        end
        S_PEMIT: begin
          if (emit_ok) begin
            out_valid_r      <= 1'b1;
            out_status_r     <= ST_FIRED;
            out_slot_r       <= cur_slot_r;
            out_tag_r        <= rd_tag;
            out_cnt_r        <= per_cnt;
            out_kind_r       <= KIND_PERIODIC;
            out_last_r       <= 1'b0;
            tl_r[cur_slot_r] <= rd_iv - div_rem;
            idx_r            <= idx_r + 1'b1;
            state_r          <= S_SCAN;
          end
        end
        S_DEFER: begin
          if (scan_end) begin
            idx_r   <= '0;
            wr_r    <= '0;
            state_r <= S_COMPACT;
          end else if (rd_valid && rd_kind == KIND_DEFERRED) begin
            if (emit_ok) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_FIRED;
              out_slot_r   <= cur;
              out_tag_r    <= rd_tag;
              out_cnt_r    <= FCNT_W'(1);
              out_kind_r   <= KIND_DEFERRED;
              out_last_r   <= 1'b0;
              valid_r[cur] <= 1'b0;
              idx_r        <= idx_r + 1'b1;
            end
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_COMPACT: begin
          if (scan_end) begin
            used_r  <= wr_r;
            state_r <= tick_r ? S_DONE : S_IDLE;
          end else begin
            if (rd_valid) begin
              order_r[wr_r[SLOT_W-1:0]] <= cur;
              wr_r                      <= wr_r + 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DONE: begin
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_TICK_DONE;
            out_slot_r   <= '0;
            out_tag_r    <= '0;
            out_cnt_r    <= '0;
            out_kind_r   <= KIND_ONCE;
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.status     = out_status_r;
  assign out_chan.slot       = out_slot_r;
  assign out_chan.fire_tag   = out_tag_r;
  assign out_chan.fire_count = out_cnt_r;
  assign out_chan.timer_kind = out_kind_r;
  assign out_chan.last       = out_last_r;
  assign sts.used_cnt        = used_r;

endmodule

@@ hdl/one_shot_periodic_timer_table_unit.sv @@
`timescale 1ns / 1ps
// Channel    Dir  Handshake      Payload
// in_chan    in   valid/ready    command, time_value, tag, slot_index
// out_chan   out  valid/ready    status, slot, fire_tag, fire_count, timer_kind, last
//
// Schedule and rejected commands finish in the back end's idle state; cancel adds one
// compaction step per listed slot.
// Tick: a scan, deferred-fire and compaction pass over the listed slots, plus an
// overrun division by the one-bit-per-cycle divider for each periodic firing.
// A 2-entry command queue keeps input accepting while the back end works.
// Reset is synchronous, active low; stalls on out_chan hold the sequencer.
module one_shot_periodic_timer_table_unit (
  input  logic        clk,
  input  logic        rst_n,
  ostpt_in_if.sink    in_chan,
  ostpt_out_if.source out_chan
);
  import ostpt_pkg::*;
  `include "one_shot_periodic_timer_table_unit_macros.svh"

  logic         q_valid;
  work_t        q_data;
  logic         q_pop;
  back_status_t sts;

  ostpt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  ostpt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .out_chan (out_chan),
    .sts      (sts)
  );

  // Check table occupancy and queue flow
  `OSPT_ASSERT_ALWAYS(a_used_bound, sts.used_cnt <= CNT_W'(NUM_SLOTS), "slot count overflow")
  `OSPT_ASSERT_ALWAYS(a_full_nonempty, in_chan.ready || q_valid, "stall with empty queue")
  `OSPT_ASSERT_NEXT(a_head_kept, q_valid && !q_pop, q_valid, "queue head lost")

endmodule
